[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle whenever the antecedent does.
`define TPM_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error("tpm: assertion failed");

// Check that a condition never holds outside reset.
`define TPM_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
    `TPM_ASSERT_IMPLY(lbl, clk_s, rst_s, 1'b1, !(cond))

`endif

[design/tpm_pkg.sv]
`default_nettype none

package tpm_pkg;

    // display size
    localparam int WIDTH  = 64;
    localparam int HEIGHT = 32;

    // field widths
    localparam int X_W        = 6;
    localparam int Y_W        = 5;
    localparam int TIME_W     = 32;
    localparam int PIX_W      = 32;
    localparam int DUR_W      = 16;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // pixel packing
    localparam int CH_W      = 8;
    localparam int CHANNELS  = 3;
    localparam int ALPHA_LSB = CHANNELS * CH_W;
    localparam int BLEND_W   = 2 * CH_W;

    // wipe band: quotient k never exceeds the larger display side
    localparam int DIM_MAX = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
    localparam int KQ_W    = $clog2(DIM_MAX + 1);
    localparam int NUM_W   = DUR_W + KQ_W;
    localparam int XY_W    = (X_W > Y_W) ? X_W : Y_W;
    localparam int CMP_W   = ((XY_W > KQ_W) ? XY_W : KQ_W) + 1;

    // ping-pong period 2D and the remainder pipeline over time_ms
    localparam int MOD_W      = DUR_W + 1;
    localparam int MOD_STAGES = TIME_W;

    // dissolve noise (37x + 17y) mod 100; the sum of the 6- and 5-bit fields fits 12 bits
    localparam int NOISE_CX     = 37;
    localparam int NOISE_CY     = 17;
    localparam int NOISE_MOD    = 100;
    localparam int NOISE_SUM_W  = 12;
    localparam int NOISE_W      = 7;
    localparam int NOISE_Q_W    = 5;
    localparam int NOISE_RECIP  = 5243;   // ceil(2^19 / 100), exact below 2^12
    localparam int NOISE_SHIFT  = 19;
    localparam int NOISE_PROD_W = NOISE_SUM_W + 13;
    localparam int HIT_W        = NOISE_W + DUR_W;

    // delay from an accepted beat to its result strobe
    localparam int LATENCY = 38 + KQ_W;

    localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = CFG_IDX_W'(2);

    typedef enum logic
    {
        MODE_DISSOLVE = 1'b0,
        MODE_WIPE     = 1'b1
    } mode_t;

    typedef enum logic [DIR_W-1:0]
    {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [1:0]
    {
        SEL_A     = 2'd0,
        SEL_BLEND = 2'd1,
        SEL_B     = 2'd2
    } sel_t;

    typedef struct packed
    {
        mode_t            mode;
        dir_t             direction;
        logic [DUR_W-1:0] dur;      // never zero
    } cfg_t;

    typedef struct packed
    {
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
    } pix_t;

    typedef struct packed
    {
        pix_t               pix;
        logic [NOISE_W-1:0] noise;
        logic [DUR_W-1:0]   pn;
    } phase_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        sel_t             sel;
    } mix_t;

    // exact v / 255 for v below 65535
    function automatic logic [CH_W-1:0] div255(input logic [BLEND_W-1:0] v);
        logic [BLEND_W:0] s;
        s = {1'b0, v} + (BLEND_W + 1)'(1) + (BLEND_W + 1)'(v[BLEND_W-1:CH_W]);
        return s[BLEND_W-1:CH_W];
    endfunction

endpackage

`default_nettype wire

[design/tpm_phase.sv]
`default_nettype none

module tpm_phase
    import tpm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire pix_t             in_pix,
    input  wire logic [TIME_W-1:0] in_time,
    input  wire logic [DUR_W-1:0] dur,
    output logic                  out_valid,
    output phase_t                out_phase
);

    logic [MOD_STAGES:0]    vld_reg;
    pix_t                   pix_reg   [0:MOD_STAGES];
    logic [TIME_W-1:0]      tq_reg    [0:MOD_STAGES-1];
    logic [MOD_W-1:0]       rem_reg   [1:MOD_STAGES];
    logic [NOISE_SUM_W-1:0] nsum_reg;
    logic [NOISE_SUM_W-1:0] nsum1_reg;
    logic [NOISE_Q_W-1:0]   nq_reg;
    logic [NOISE_W-1:0]     noise_reg [2:MOD_STAGES];
    logic                   out_valid_reg;
    phase_t                 phase_reg;

    logic [MOD_W-1:0]        modulus;
    logic [NOISE_SUM_W-1:0]  nsum_next;
    logic [NOISE_PROD_W-1:0] nprod;
    logic [MOD_W-1:0]        t_last;
    logic [DUR_W-1:0]        pn_next;

    assign modulus   = {dur, 1'b0};
    assign nsum_next = NOISE_SUM_W'(in_pix.x) * NOISE_SUM_W'(NOISE_CX)
                     + NOISE_SUM_W'(in_pix.y) * NOISE_SUM_W'(NOISE_CY);
    assign nprod     = NOISE_PROD_W'(nsum_reg) * NOISE_PROD_W'(NOISE_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[MOD_STAGES-1:0], in_valid};
            out_valid_reg <= vld_reg[MOD_STAGES];
        end
    end

    // capture, then noise side chain alongside the remainder stages
    always_ff @(posedge clk)
    begin
        pix_reg[0]   <= in_pix;
        tq_reg[0]    <= in_time;
        nsum_reg     <= nsum_next;
        nsum1_reg    <= nsum_reg;
        nq_reg       <= nprod[NOISE_SHIFT +: NOISE_Q_W];
        noise_reg[2] <= NOISE_W'(nsum1_reg - NOISE_SUM_W'(nq_reg) * NOISE_SUM_W'(NOISE_MOD));
        for (int j = 3; j <= MOD_STAGES; j++)
        begin
            noise_reg[j] <= noise_reg[j-1];
        end
    end

    // one remainder bit per stage, most significant time bit first
    for (genvar i = 0; i < MOD_STAGES; i++)
    begin : g_mod
        logic [MOD_W-1:0] rem_in;
        logic [MOD_W:0]   sh;
        logic [MOD_W:0]   diff;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i];
        end

        assign sh   = {rem_in, tq_reg[i][TIME_W-1]};
        assign diff = sh - {1'b0, modulus};

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= (sh >= {1'b0, modulus}) ? diff[MOD_W-1:0] : sh[MOD_W-1:0];
            pix_reg[i+1] <= pix_reg[i];
        end

        if (i + 1 < MOD_STAGES)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                tq_reg[i+1] <= {tq_reg[i][TIME_W-2:0], 1'b0};
            end
        end
    end

    // fold the second half period back
    assign t_last  = rem_reg[MOD_STAGES];
    assign pn_next = (t_last < {1'b0, dur}) ? t_last[DUR_W-1:0] : DUR_W'(modulus - t_last);

    always_ff @(posedge clk)
    begin
        phase_reg.pix   <= pix_reg[MOD_STAGES];
        phase_reg.noise <= noise_reg[MOD_STAGES];
        phase_reg.pn    <= pn_next;
    end

    assign out_valid = out_valid_reg;
    assign out_phase = phase_reg;

endmodule

`default_nettype wire

[design/tpm_band.sv]
`default_nettype none

module tpm_band
    import tpm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire phase_t in_phase,
    input  wire cfg_t   cfg,
    output logic        out_valid,
    output mix_t        out_mix
);

    logic [KQ_W:0]     vld_reg;
    logic [KQ_W:0]     hit_reg;
    pix_t              pix_reg [0:KQ_W];
    logic [DUR_W-1:0]  rem_reg [0:KQ_W-1];
    logic [KQ_W-1:0]   lo_reg  [0:KQ_W-1];
    logic [KQ_W-1:0]   q_reg   [1:KQ_W];
    logic              out_valid_reg;
    mix_t              mix_reg;

    logic              rows;
    logic [NUM_W-1:0]  num_next;
    logic              hit_next;
    logic [CMP_W-1:0]  xe;
    logic [CMP_W-1:0]  ye;
    logic [CMP_W-1:0]  ke;
    logic              in_range;
    logic              in_band;
    sel_t              sel_next;

    // band width k = floor(dim * pn / D); dissolve hit compares in parallel
    assign rows     = (cfg.direction == DIR_UP) || (cfg.direction == DIR_DOWN);
    assign num_next = NUM_W'(in_phase.pn) * (rows ? NUM_W'(HEIGHT) : NUM_W'(WIDTH));
    assign hit_next = (HIT_W'(in_phase.noise) * HIT_W'(cfg.dur))
                    < (HIT_W'(in_phase.pn) * HIT_W'(NOISE_MOD));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[KQ_W-1:0], in_valid};
            out_valid_reg <= vld_reg[KQ_W];
        end
    end

    // the top bits of num are already below D, so only KQ_W quotient bits remain
    always_ff @(posedge clk)
    begin
        pix_reg[0] <= in_phase.pix;
        hit_reg[0] <= hit_next;
        rem_reg[0] <= num_next[NUM_W-1:KQ_W];
        lo_reg[0]  <= num_next[KQ_W-1:0];
    end

    for (genvar j = 0; j < KQ_W; j++)
    begin : g_div
        logic [KQ_W-1:0]  q_in;
        logic [DUR_W:0]   sh;
        logic [DUR_W:0]   diff;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign q_in = q_reg[j];
        end

        assign sh   = {rem_reg[j], lo_reg[j][KQ_W-1-j]};
        assign diff = sh - {1'b0, cfg.dur};
        assign ge   = sh >= {1'b0, cfg.dur};

        always_ff @(posedge clk)
        begin
            q_reg[j+1]   <= KQ_W'({q_in, ge});
            pix_reg[j+1] <= pix_reg[j];
            hit_reg[j+1] <= hit_reg[j];
        end

        if (j + 1 < KQ_W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j+1] <= ge ? diff[DUR_W-1:0] : sh[DUR_W-1:0];
                lo_reg[j+1]  <= lo_reg[j];
            end
        end
    end

    assign xe       = CMP_W'(pix_reg[KQ_W].x);
    assign ye       = CMP_W'(pix_reg[KQ_W].y);
    assign ke       = CMP_W'(q_reg[KQ_W]);
    assign in_range = (xe < CMP_W'(WIDTH)) && (ye < CMP_W'(HEIGHT));

    always_comb
    begin
        in_band = 1'b0;
        unique case (cfg.direction)
            DIR_LEFT:  in_band = (xe + ke) >= CMP_W'(WIDTH);
            DIR_RIGHT: in_band = xe < ke;
            DIR_UP:    in_band = (ye + ke) >= CMP_W'(HEIGHT);
            DIR_DOWN:  in_band = ye < ke;
            default:   in_band = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (!in_range)
            sel_next = SEL_A;
        else if (cfg.mode == MODE_DISSOLVE)
            sel_next = hit_reg[KQ_W] ? SEL_BLEND : SEL_A;
        else
            sel_next = in_band ? SEL_B : SEL_A;
    end

    always_ff @(posedge clk)
    begin
        mix_reg.a   <= pix_reg[KQ_W].a;
        mix_reg.b   <= pix_reg[KQ_W].b;
        mix_reg.sel <= sel_next;
    end

    assign out_valid = out_valid_reg;
    assign out_mix   = mix_reg;

endmodule

`default_nettype wire

[design/tpm_blend.sv]
`default_nettype none

module tpm_blend
    import tpm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire mix_t        in_mix,
    output logic             out_valid,
    output logic [PIX_W-1:0] out_pixel
);

    logic                 vld_reg;
    logic [BLEND_W-1:0]   csum_reg [0:CHANNELS-1];
    logic [BLEND_W-1:0]   asum_reg;
    logic [CH_W-1:0]      ab_reg;
    mix_t                 mix_reg;
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     pixel_reg;

    logic [CH_W-1:0]      ab;
    logic [CH_W-1:0]      inv;
    logic [BLEND_W-1:0]   csum_next [0:CHANNELS-1];
    logic [BLEND_W-1:0]   asum_next;
    logic [CH_W:0]        alpha_sum;
    logic [PIX_W-1:0]     blended;
    logic [PIX_W-1:0]     pixel_next;

    assign ab  = in_mix.b[ALPHA_LSB +: CH_W];
    assign inv = {CH_W{1'b1}} - ab;

    // products and rounding bias; each sum stays below 65536
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            csum_next[c] = BLEND_W'(in_mix.b[c*CH_W +: CH_W]) * BLEND_W'(ab)
                         + BLEND_W'(in_mix.a[c*CH_W +: CH_W]) * BLEND_W'(inv)
                         + BLEND_W'(127);
        end
    end

    assign asum_next = BLEND_W'(in_mix.a[ALPHA_LSB +: CH_W]) * BLEND_W'(inv) + BLEND_W'(127);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= in_valid;
            out_valid_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            csum_reg[c] <= csum_next[c];
        end
        asum_reg <= asum_next;
        ab_reg   <= ab;
        mix_reg  <= in_mix;
    end

    // divide by 255, saturate alpha, pick the source
    assign alpha_sum = (CH_W + 1)'(ab_reg) + (CH_W + 1)'(div255(asum_reg));

    always_comb
    begin
        blended = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            blended[c*CH_W +: CH_W] = div255(csum_reg[c]);
        end
        blended[ALPHA_LSB +: CH_W] = alpha_sum[CH_W] ? {CH_W{1'b1}} : alpha_sum[CH_W-1:0];
    end

    always_comb
    begin
        unique case (mix_reg.sel)
            SEL_A:     pixel_next = mix_reg.a;
            SEL_BLEND: pixel_next = blended;
            SEL_B:     pixel_next = mix_reg.b;
            default:   pixel_next = mix_reg.a;
        endcase
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = pixel_reg;

endmodule

`default_nettype wire

[design/transition_pixel_mixer.sv]
// Channel   Ports                                            Beat taken at
// --------  -----------------------------------------------  ----------------------------
// pixel in  start, busy, pixel_x, pixel_y, time_ms,          rising edge, start && !busy
//           pixel_a, pixel_b
// result    done, pixel_out                                  rising edge ending done cycle
// config    cfg_we, cfg_index, cfg_data                      rising edge with cfg_we high
//
// One pixel beat enters every cycle; busy stays low.
// The latency is set mostly by the 32-stage restoring remainder pipeline that
// folds time_ms into the ping-pong period.
// rst_n clears the stage valid bits and loads the configuration reset values at once.
// The receiver cannot stall: each result shows for exactly one cycle with done high.
`default_nettype none

module transition_pixel_mixer
    import tpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // pixel beats
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [X_W-1:0]        pixel_x,
    input  wire logic [Y_W-1:0]        pixel_y,
    input  wire logic [TIME_W-1:0]     time_ms,
    input  wire logic [PIX_W-1:0]      pixel_a,
    input  wire logic [PIX_W-1:0]      pixel_b,
    // results
    output logic                       done,
    output logic [PIX_W-1:0]           pixel_out,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    mode_t            mode_reg;
    dir_t             direction_reg;
    logic [DUR_W-1:0] duration_reg;

    cfg_t             cfg;
    pix_t             in_pix;
    logic             accept;
    logic             phase_valid;
    phase_t           phase;
    logic             band_valid;
    mix_t             mix;

    // Hold the configuration. A zero duration is stored as one, so the
    // remainder and band dividers never see a zero divisor. Drop writes to
    // indexes beyond the register list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DISSOLVE;
            direction_reg <= DIR_LEFT;
            duration_reg  <= DUR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= mode_t'(cfg_data[0]);
                REG_DIRECTION: direction_reg <= dir_t'(cfg_data[DIR_W-1:0]);
                REG_DURATION:  duration_reg  <= (cfg_data == '0) ? DUR_W'(1)
                                                                 : cfg_data[DUR_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg.mode      = mode_reg;
    assign cfg.direction = direction_reg;
    assign cfg.dur       = duration_reg;

    // Every stage advances every cycle, so a beat is never refused.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_pix.x = pixel_x;
    assign in_pix.y = pixel_y;
    assign in_pix.a = pixel_a;
    assign in_pix.b = pixel_b;

    // Fold time into the progress numerator pn and compute the dissolve noise.
    tpm_phase u_phase
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_pix    (in_pix),
        .in_time   (time_ms),
        .dur       (cfg.dur),
        .out_valid (phase_valid),
        .out_phase (phase)
    );

    // Work out the wipe band and the dissolve threshold, then choose the source.
    tpm_band u_band
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (phase_valid),
        .in_phase  (phase),
        .cfg       (cfg),
        .out_valid (band_valid),
        .out_mix   (mix)
    );

    // Blend B over A or pass either source through, and register the result beat.
    tpm_blend u_blend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (band_valid),
        .in_mix    (mix),
        .out_valid (done),
        .out_pixel (pixel_out)
    );

endmodule

`default_nettype wire

[design/tpm_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module tpm_checker
    import tpm_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic [PIX_W-1:0]      pixel_a,
    input wire logic [PIX_W-1:0]      pixel_b,
    input wire logic                  done,
    input wire logic [PIX_W-1:0]      pixel_out
);

    localparam int SINCE_W = $clog2(LATENCY + 1);

    logic [SINCE_W-1:0] since_reg;
    logic [SINCE_W-1:0] since_next;
    logic               since_full;
    logic               opaque_same;

    // count cycles out of reset, saturating at the pipeline latency
    assign since_full = since_reg == SINCE_W'(LATENCY);
    assign since_next = since_full ? since_reg : since_reg + SINCE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            since_reg <= '0;
        else
            since_reg <= since_next;
    end

    // an opaque pixel composited with itself comes out unchanged in every mode
    assign opaque_same = start && !busy && (pixel_a == pixel_b)
                      && (pixel_a[ALPHA_LSB +: CH_W] == {CH_W{1'b1}});

    `TPM_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)

    `TPM_ASSERT_IMPLY(a_done_has_beat, clk, rst_n, done, $past(start && !busy, LATENCY))

    `TPM_ASSERT_IMPLY(a_beat_gives_done, clk, rst_n, since_full && $past(start && !busy, LATENCY), done)

    `TPM_ASSERT_IMPLY(a_opaque_identity, clk, rst_n, done && $past(opaque_same, LATENCY), pixel_out == $past(pixel_a, LATENCY))

endmodule

bind transition_pixel_mixer tpm_checker u_tpm_checker (.*);

`default_nettype wire
